### src/rtsv_pkg.sv
// Package for the redundant temperature sensor voter.
// Holds register indexes, reset values, debounce and window constants and output codes.
// No dependencies; used by redundant_temp_sensor_voter.
package rtsv_pkg;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 40;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VALID_LOW     = 3'd0,
    REG_VALID_HIGH    = 3'd1,
    REG_AGREE_LIMIT   = 3'd2,
    REG_STUCK_LIMIT   = 3'd3,
    REG_MOVED_LIMIT   = 3'd4,
    REG_WARNING_LEVEL = 3'd5,
    REG_TRIP_LEVEL    = 3'd6,
    REG_INIT_TIME_MS  = 3'd7
  } reg_index_t;

  // Register reset values
  localparam logic signed [11:0] VALID_LOW_RST     = 12'sd0;
  localparam logic signed [11:0] VALID_HIGH_RST    = 12'sd1280;
  localparam logic        [11:0] AGREE_LIMIT_RST   = 12'd16;
  localparam logic        [11:0] STUCK_LIMIT_RST   = 12'd1;
  localparam logic        [11:0] MOVED_LIMIT_RST   = 12'd8;
  localparam logic signed [11:0] WARNING_LEVEL_RST = 12'sd800;
  localparam logic signed [11:0] TRIP_LEVEL_RST    = 12'sd960;
  localparam logic        [15:0] INIT_TIME_MS_RST  = 16'd3000;

  // Debounce and stuck-window lengths
  localparam logic [1:0] CONFIRM_COUNT = 2'd3;
  localparam logic [1:0] CLEAR_COUNT   = 2'd3;
  localparam logic [1:0] COUNT_SAT     = 2'd3;
  localparam logic [2:0] STUCK_WINDOW  = 3'd5;

  typedef enum logic [2:0] {
    DIAG_OK        = 3'd0,
    DIAG_A_FAULT   = 3'd1,
    DIAG_B_FAULT   = 3'd2,
    DIAG_DISAGREE  = 3'd3,
    DIAG_NONE_VALID = 3'd4,
    DIAG_A_STUCK   = 3'd5,
    DIAG_B_STUCK   = 3'd6,
    DIAG_PENDING   = 3'd7
  } diag_t;

  typedef enum logic [1:0] {
    ST_INIT    = 2'd0,
    ST_NORMAL  = 2'd1,
    ST_WARNING = 2'd2,
    ST_TRIP    = 2'd3
  } proc_state_t;

endpackage

### src/redundant_temp_sensor_voter.sv
// Redundant temperature sensor voter, top level.
// Input register, single-pass vote/debounce/stuck/state logic, result register.
// Depends on rtsv_pkg.

// Each input beat carries one sample pair from two redundant sensors (1/16 degree
// units), a millisecond timestamp and two supervisor flags. The block accepts one
// beat per clock and returns exactly one result beat per input beat, in order.
// A beat waits in the input register while the voter logic runs and is written
// into the result register once that register is free, and its result stays
// there until it is taken.
// With the output ready, one item per cycle goes in and out; a stalled result
// holds the input register, which then holds off the input. Disagreement is
// confirmed after three bad samples and cleared after three good ones; the
// stuck-sensor check compares each sensor against a snapshot taken every five
// valid samples. The trusted temperature comes out in 1/32 degree units.
// Configuration writes take effect at the next edge and must only be made while
// no item is in flight.
module redundant_temp_sensor_voter (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // temp_a[11:0], temp_b[23:12], time_ms[55:24], comms_ok[56],
  // heat_request[57], zero pad[63:58]
  input  logic [rtsv_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // a_valid[0], b_valid[1], agree[2], difference[14:3], diag_code[17:15],
  // trusted_temp[30:18], trusted_valid[31], proc_state[33:32], init_done[34],
  // permissive[35], heater_on[36], zero pad[39:37]
  output logic [rtsv_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // Configuration write port
  input  logic                                cfg_wr_en,
  input  logic [rtsv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rtsv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers
  logic signed [11:0] valid_low;
  logic signed [11:0] valid_high;
  logic        [11:0] agree_limit;
  logic        [11:0] stuck_limit;
  logic        [11:0] moved_limit;
  logic signed [11:0] warning_level;
  logic signed [11:0] trip_level;
  logic        [15:0] init_time_ms;

  // Input register
  logic                           in_valid;
  logic [rtsv_pkg::IN_DATA_W-1:0] in_data;
  logic                           in_fire;

  // Voter state
  logic [1:0]                bad_count, bad_count_next;
  logic [1:0]                good_count, good_count_next;
  logic                      disagree_confirmed, disagree_confirmed_next;
  logic                      disagree_pending, disagree_pending_next;
  logic                      window_started, window_started_next;
  logic signed [11:0]        window_start_a, window_start_a_next;
  logic signed [11:0]        window_start_b, window_start_b_next;
  logic [2:0]                window_count, window_count_next;
  logic                      a_stuck, a_stuck_next;
  logic                      b_stuck, b_stuck_next;
  logic signed [12:0]        last_trusted, last_trusted_next;
  logic                      last_trusted_valid, last_trusted_valid_next;
  logic                      initialized, initialized_next;
  rtsv_pkg::proc_state_t     state_reg, state_reg_next;

  // Per-item combinational values
  logic signed [11:0]        temp_a, temp_b;
  logic [31:0]               time_ms;
  logic                      comms_ok, heat_request;
  logic                      av, bv, both_valid, agree;
  logic [11:0]               difference;
  logic [11:0]               change_a, change_b;
  logic [2:0]                window_inc;
  rtsv_pkg::diag_t           diag;
  logic signed [12:0]        trusted;
  logic                      tvalid;
  logic signed [12:0]        trusted_out;
  logic                      perm;
  logic [rtsv_pkg::OUT_DATA_W-1:0] result;

  // |x - y| of two 12-bit signed values; always fits 12 bits unsigned
  function automatic logic [11:0] abs_diff12(input logic signed [11:0] x,
                                             input logic signed [11:0] y);
    logic signed [12:0] d;
    logic signed [12:0] m;
    d = 13'({x[11], x}) - 13'({y[11], y});
    m = -d;
    return d[12] ? m[11:0] : d[11:0];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_low     <= rtsv_pkg::VALID_LOW_RST;
      valid_high    <= rtsv_pkg::VALID_HIGH_RST;
      agree_limit   <= rtsv_pkg::AGREE_LIMIT_RST;
      stuck_limit   <= rtsv_pkg::STUCK_LIMIT_RST;
      moved_limit   <= rtsv_pkg::MOVED_LIMIT_RST;
      warning_level <= rtsv_pkg::WARNING_LEVEL_RST;
      trip_level    <= rtsv_pkg::TRIP_LEVEL_RST;
      init_time_ms  <= rtsv_pkg::INIT_TIME_MS_RST;
    end else if (cfg_wr_en) begin
      case (rtsv_pkg::reg_index_t'(cfg_index))
        rtsv_pkg::REG_VALID_LOW:     valid_low     <= cfg_data[11:0];
        rtsv_pkg::REG_VALID_HIGH:    valid_high    <= cfg_data[11:0];
        rtsv_pkg::REG_AGREE_LIMIT:   agree_limit   <= cfg_data[11:0];
        rtsv_pkg::REG_STUCK_LIMIT:   stuck_limit   <= cfg_data[11:0];
        rtsv_pkg::REG_MOVED_LIMIT:   moved_limit   <= cfg_data[11:0];
        rtsv_pkg::REG_WARNING_LEVEL: warning_level <= cfg_data[11:0];
        rtsv_pkg::REG_TRIP_LEVEL:    trip_level    <= cfg_data[11:0];
        rtsv_pkg::REG_INIT_TIME_MS:  init_time_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free
  assign in_fire       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
    end
  end

  // Field unpacking
  assign temp_a       = in_data[11:0];
  assign temp_b       = in_data[23:12];
  assign time_ms      = in_data[55:24];
  assign comms_ok     = in_data[56];
  assign heat_request = in_data[57];

  // Range check, agreement, window changes
  assign av         = (temp_a >= valid_low) && (temp_a <= valid_high);
  assign bv         = (temp_b >= valid_low) && (temp_b <= valid_high);
  assign both_valid = av && bv;
  assign difference = both_valid ? abs_diff12(temp_a, temp_b) : 12'd0;
  assign agree      = both_valid && (difference <= agree_limit);
  assign change_a   = abs_diff12(temp_a, window_start_a);
  assign change_b   = abs_diff12(temp_b, window_start_b);
  assign window_inc = window_count + 3'd1;

  // Disagreement debounce and stuck window
  always_comb begin
    bad_count_next          = bad_count;
    good_count_next         = good_count;
    disagree_confirmed_next = disagree_confirmed;
    disagree_pending_next   = disagree_pending;
    window_started_next     = window_started;
    window_start_a_next     = window_start_a;
    window_start_b_next     = window_start_b;
    window_count_next       = window_count;
    a_stuck_next            = a_stuck;
    b_stuck_next            = b_stuck;

    if (both_valid) begin
      if (!agree) begin
        good_count_next = 2'd0;
        if (!disagree_confirmed) begin
          if (bad_count < rtsv_pkg::COUNT_SAT) begin
            bad_count_next = bad_count + 2'd1;
          end
          disagree_pending_next = 1'b1;
          if (bad_count_next >= rtsv_pkg::CONFIRM_COUNT) begin
            disagree_confirmed_next = 1'b1;
            disagree_pending_next   = 1'b0;
          end
        end
      end else begin
        bad_count_next        = 2'd0;
        disagree_pending_next = 1'b0;
        if (disagree_confirmed) begin
          if (good_count < rtsv_pkg::COUNT_SAT) begin
            good_count_next = good_count + 2'd1;
          end
          if (good_count_next >= rtsv_pkg::CLEAR_COUNT) begin
            disagree_confirmed_next = 1'b0;
            good_count_next         = 2'd0;
          end
        end else begin
          good_count_next = 2'd0;
        end
      end
    end else begin
      bad_count_next          = 2'd0;
      good_count_next         = 2'd0;
      disagree_pending_next   = 1'b0;
      disagree_confirmed_next = 1'b0;
    end

    if (!both_valid) begin
      a_stuck_next        = 1'b0;
      b_stuck_next        = 1'b0;
      window_started_next = 1'b0;
      window_count_next   = 3'd0;
    end else if (!window_started) begin
      window_start_a_next = temp_a;
      window_start_b_next = temp_b;
      window_count_next   = 3'd0;
      window_started_next = 1'b1;
    end else if (window_inc >= rtsv_pkg::STUCK_WINDOW) begin
      a_stuck_next        = (change_a <= stuck_limit) &&
                            (change_b >= moved_limit);
      b_stuck_next        = (change_b <= stuck_limit) &&
                            (change_a >= moved_limit);
      window_start_a_next = temp_a;
      window_start_b_next = temp_b;
      window_count_next   = 3'd0;
    end else begin
      window_count_next = window_inc;
    end
  end

  // Priority-ordered diagnostic code
  always_comb begin
    if (a_stuck_next)                 diag = rtsv_pkg::DIAG_A_STUCK;
    else if (b_stuck_next)            diag = rtsv_pkg::DIAG_B_STUCK;
    else if (disagree_confirmed_next) diag = rtsv_pkg::DIAG_DISAGREE;
    else if (disagree_pending_next)   diag = rtsv_pkg::DIAG_PENDING;
    else if (agree)                   diag = rtsv_pkg::DIAG_OK;
    else if (av && !bv)               diag = rtsv_pkg::DIAG_B_FAULT;
    else if (!av && bv)               diag = rtsv_pkg::DIAG_A_FAULT;
    else                              diag = rtsv_pkg::DIAG_NONE_VALID;
  end

  // Trusted temperature in 1/32 degree, process state and permissive
  always_comb begin
    trusted                 = 13'sd0;
    tvalid                  = 1'b0;
    last_trusted_next       = last_trusted;
    last_trusted_valid_next = last_trusted_valid;
    initialized_next        = initialized;
    state_reg_next          = state_reg;

    if (a_stuck_next && bv) begin
      trusted = {temp_b, 1'b0};
      tvalid  = 1'b1;
    end else if (b_stuck_next && av) begin
      trusted = {temp_a, 1'b0};
      tvalid  = 1'b1;
    end else if (av != bv) begin
      trusted = av ? {temp_a, 1'b0} : {temp_b, 1'b0};
      tvalid  = 1'b1;
    end else if (disagree_confirmed_next) begin
      tvalid = 1'b0;
    end else if (agree) begin
      trusted = 13'({temp_a[11], temp_a}) + 13'({temp_b[11], temp_b});
      tvalid  = 1'b1;
    end else if (disagree_pending_next && last_trusted_valid) begin
      trusted = last_trusted;
      tvalid  = 1'b1;
    end

    // A held value during a pending disagreement is not stored again
    if (tvalid && !(disagree_pending_next && !agree &&
                     !(a_stuck_next || b_stuck_next) && (av == bv))) begin
      last_trusted_next       = trusted;
      last_trusted_valid_next = 1'b1;
    end

    // Levels are doubled into 1/32 degree and compared signed
    if (!initialized) begin
      state_reg_next = rtsv_pkg::ST_INIT;
      if ((time_ms >= {16'd0, init_time_ms}) && tvalid) begin
        initialized_next = 1'b1;
      end
    end else if (tvalid) begin
      if (trusted >= $signed({trip_level, 1'b0})) begin
        state_reg_next = rtsv_pkg::ST_TRIP;
      end else if (trusted >= $signed({warning_level, 1'b0})) begin
        state_reg_next = rtsv_pkg::ST_WARNING;
      end else begin
        state_reg_next = rtsv_pkg::ST_NORMAL;
      end
    end

    perm = initialized_next && tvalid && comms_ok &&
           ((state_reg_next == rtsv_pkg::ST_NORMAL) ||
            (state_reg_next == rtsv_pkg::ST_WARNING));
    trusted_out = tvalid ? trusted : 13'sd0;
  end

  assign result = {3'b000, perm && heat_request, perm, initialized_next, state_reg_next,
                   tvalid, trusted_out, diag, difference, agree, bv, av};

  // State update, one item per in_fire
  always_ff @(posedge clk) begin
    if (rst) begin
      bad_count          <= 2'd0;
      good_count         <= 2'd0;
      disagree_confirmed <= 1'b0;
      disagree_pending   <= 1'b0;
      window_started     <= 1'b0;
      window_start_a     <= 12'sd0;
      window_start_b     <= 12'sd0;
      window_count       <= 3'd0;
      a_stuck            <= 1'b0;
      b_stuck            <= 1'b0;
      last_trusted       <= 13'sd0;
      last_trusted_valid <= 1'b0;
      initialized        <= 1'b0;
      state_reg          <= rtsv_pkg::ST_INIT;
    end else if (in_fire) begin
      bad_count          <= bad_count_next;
      good_count         <= good_count_next;
      disagree_confirmed <= disagree_confirmed_next;
      disagree_pending   <= disagree_pending_next;
      window_started     <= window_started_next;
      window_start_a     <= window_start_a_next;
      window_start_b     <= window_start_b_next;
      window_count       <= window_count_next;
      a_stuck            <= a_stuck_next;
      b_stuck            <= b_stuck_next;
      last_trusted       <= last_trusted_next;
      last_trusted_valid <= last_trusted_valid_next;
      initialized        <= initialized_next;
      state_reg          <= state_reg_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= result;
    end
  end

  // Checks
  a_pend_conf_excl: assert property (@(posedge clk) disable iff (rst)
    !(disagree_pending && disagree_confirmed))
    else $error("disagreement both pending and confirmed");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    window_count < rtsv_pkg::STUCK_WINDOW)
    else $error("stuck window count ran past window length");

  a_init_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(initialized))
    else $error("initialized dropped without reset");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_fire |=> in_valid && $stable(in_data))
    else $error("stalled input item lost or overwritten");

endmodule

### tb/redundant_temp_sensor_voter_tb.sv
// Self-checking testbench for redundant_temp_sensor_voter: directed and scenario-based random
// sample pairs, a per-sample vote predictor and a result scoreboard.
// Depends on rtsv_pkg and the redundant_temp_sensor_voter RTL.
module redundant_temp_sensor_voter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [11:0] ta;
    logic signed [11:0] tb;
    logic [31:0]        ms;
    logic               comms;
    logic               heat;
  } sample_t;

  typedef struct {
    logic                  a_ok;
    logic                  b_ok;
    logic                  agree;
    logic [11:0]           diff;
    rtsv_pkg::diag_t       diag;
    logic signed [12:0]    trusted;
    logic                  trusted_ok;
    rtsv_pkg::proc_state_t state;
    logic                  init_done;
    logic                  permissive;
    logic                  heater_on;
  } verdict_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // DUT-facing signals; those the bench drives are known from time zero
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [rtsv_pkg::IN_DATA_W-1:0]   s_tdata   = '0;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [rtsv_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic                             cfg_wr_en = 1'b0;
  logic [rtsv_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rtsv_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  redundant_temp_sensor_voter DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Stimulus backlog, expected verdicts, bookkeeping
  sample_t  sample_backlog[$];
  verdict_t expected_verdicts[$];
  sample_t  beat_now;
  verdict_t want;
  int       mismatch_count = 0;
  int       src_gap_pct    = 6;
  int       snk_gap_pct    = 6;
  bit       stall_armed    = 1'b0;
  bit       stall_done     = 1'b0;
  int       stall_left     = 0;
  int       phase_beats    = 0;
  int       walk_t         = 400;
  logic [31:0] clock_ms    = 32'd80000;

  // Register copies seen by the predictor
  logic signed [11:0] lo_lim      = rtsv_pkg::VALID_LOW_RST;
  logic signed [11:0] hi_lim      = rtsv_pkg::VALID_HIGH_RST;
  logic        [11:0] agree_lim   = rtsv_pkg::AGREE_LIMIT_RST;
  logic        [11:0] stuck_lim   = rtsv_pkg::STUCK_LIMIT_RST;
  logic        [11:0] moved_lim   = rtsv_pkg::MOVED_LIMIT_RST;
  logic signed [11:0] warn_lim    = rtsv_pkg::WARNING_LEVEL_RST;
  logic signed [11:0] trip_lim    = rtsv_pkg::TRIP_LEVEL_RST;
  logic        [15:0] init_ms_lim = rtsv_pkg::INIT_TIME_MS_RST;

  // Voter state mirror
  logic [1:0]            bad_run       = '0;
  logic [1:0]            good_run      = '0;
  bit                    dis_confirmed = 1'b0;
  bit                    dis_pending   = 1'b0;
  bit                    win_open      = 1'b0;
  logic signed [11:0]    win_ref_a     = '0;
  logic signed [11:0]    win_ref_b     = '0;
  logic [2:0]            win_count     = '0;
  bit                    stuck_a       = 1'b0;
  bit                    stuck_b       = 1'b0;
  logic signed [12:0]    held_trusted  = '0;
  bit                    held_valid    = 1'b0;
  bit                    init_seen     = 1'b0;
  rtsv_pkg::proc_state_t proc_now      = rtsv_pkg::ST_INIT;

  // Vote one sample pair and advance the mirrored state
  function automatic verdict_t vote_predict(input sample_t s);
    verdict_t v;
    int a, b, lo, hi, dev, ca, cb, tr;
    bit av, bv, agr, tv;
    rtsv_pkg::diag_t dg;
    a = s.ta;
    b = s.tb;
    lo = lo_lim;
    hi = hi_lim;
    av = (a >= lo) && (a <= hi);
    bv = (b >= lo) && (b <= hi);
    agr = 1'b0;
    dev = 0;
    tr = 0;
    tv = 1'b0;

    // disagreement debounce
    if (av && bv) begin
      dev = (a > b) ? a - b : b - a;
      if (dev > 4095) dev = 4095;
      agr = (dev <= int'(agree_lim));
      if (!agr) begin
        good_run = '0;
        if (!dis_confirmed) begin
          if (bad_run < rtsv_pkg::COUNT_SAT) bad_run = bad_run + 2'd1;
          dis_pending = 1'b1;
          if (bad_run >= rtsv_pkg::CONFIRM_COUNT) begin
            dis_confirmed = 1'b1;
            dis_pending = 1'b0;
          end
        end
      end else begin
        bad_run = '0;
        dis_pending = 1'b0;
        if (dis_confirmed) begin
          if (good_run < rtsv_pkg::COUNT_SAT) good_run = good_run + 2'd1;
          if (good_run >= rtsv_pkg::CLEAR_COUNT) begin
            dis_confirmed = 1'b0;
            good_run = '0;
          end
        end else begin
          good_run = '0;
        end
      end
    end else begin
      bad_run = '0;
      good_run = '0;
      dis_pending = 1'b0;
      dis_confirmed = 1'b0;
    end

    // stuck-sensor window
    if (!av || !bv) begin
      stuck_a = 1'b0;
      stuck_b = 1'b0;
      win_open = 1'b0;
      win_count = '0;
    end else if (!win_open) begin
      win_ref_a = s.ta;
      win_ref_b = s.tb;
      win_count = '0;
      win_open = 1'b1;
    end else begin
      win_count = win_count + 3'd1;
      if (win_count >= rtsv_pkg::STUCK_WINDOW) begin
        ca = (a > int'(win_ref_a)) ? a - int'(win_ref_a) : int'(win_ref_a) - a;
        cb = (b > int'(win_ref_b)) ? b - int'(win_ref_b) : int'(win_ref_b) - b;
        stuck_a = (ca <= int'(stuck_lim)) && (cb >= int'(moved_lim));
        stuck_b = (cb <= int'(stuck_lim)) && (ca >= int'(moved_lim));
        win_ref_a = s.ta;
        win_ref_b = s.tb;
        win_count = '0;
      end
    end

    // diagnostic priority
    if (stuck_a)            dg = rtsv_pkg::DIAG_A_STUCK;
    else if (stuck_b)       dg = rtsv_pkg::DIAG_B_STUCK;
    else if (dis_confirmed) dg = rtsv_pkg::DIAG_DISAGREE;
    else if (dis_pending)   dg = rtsv_pkg::DIAG_PENDING;
    else if (agr)           dg = rtsv_pkg::DIAG_OK;
    else if (av && !bv)     dg = rtsv_pkg::DIAG_B_FAULT;
    else if (!av && bv)     dg = rtsv_pkg::DIAG_A_FAULT;
    else                    dg = rtsv_pkg::DIAG_NONE_VALID;

    // trusted value in 1/32 degree
    if (stuck_a && bv) begin
      tr = 2 * b;
      tv = 1'b1;
    end else if (stuck_b && av) begin
      tr = 2 * a;
      tv = 1'b1;
    end else if (av != bv) begin
      tr = av ? 2 * a : 2 * b;
      tv = 1'b1;
    end else if (dis_confirmed) begin
      tv = 1'b0;
    end else if (agr) begin
      tr = a + b;
      tv = 1'b1;
    end else if (dis_pending && held_valid) begin
      tr = held_trusted;
      tv = 1'b1;
    end
    if (tv && !(dis_pending && !agr && !(stuck_a || stuck_b) && av == bv)) begin
      held_trusted = tr[12:0];
      held_valid = 1'b1;
    end

    // process state; the completing sample still reports initializing
    if (!init_seen) begin
      proc_now = rtsv_pkg::ST_INIT;
      if (s.ms >= {16'd0, init_ms_lim} && tv) init_seen = 1'b1;
    end else if (tv) begin
      if (tr >= 2 * int'(trip_lim))      proc_now = rtsv_pkg::ST_TRIP;
      else if (tr >= 2 * int'(warn_lim)) proc_now = rtsv_pkg::ST_WARNING;
      else                               proc_now = rtsv_pkg::ST_NORMAL;
    end

    v.a_ok       = av;
    v.b_ok       = bv;
    v.agree      = agr;
    v.diff       = dev[11:0];
    v.diag       = dg;
    v.trusted    = tv ? tr[12:0] : 13'sd0;
    v.trusted_ok = tv;
    v.state      = proc_now;
    v.init_done  = init_seen;
    v.permissive = init_seen && tv && s.comms &&
                   (proc_now == rtsv_pkg::ST_NORMAL || proc_now == rtsv_pkg::ST_WARNING);
    v.heater_on  = v.permissive && s.heat;
    return v;
  endfunction

  // Driver: offers backlog beats, holds a beat until taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_verdicts.push_back(vote_predict(beat_now));
      if (!s_tvalid || s_tready) begin
        if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
          beat_now = sample_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'd0, beat_now.heat, beat_now.comms, beat_now.ms,
                       beat_now.tb, beat_now.ta};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Monitor: result checks and output backpressure, including one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat arrived with no expected verdict pending");
          mismatch_count++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("a_valid", want.a_ok, m_tdata[0]);
          check_field("b_valid", want.b_ok, m_tdata[1]);
          check_field("agree", want.agree, m_tdata[2]);
          check_field("difference", want.diff, m_tdata[14:3]);
          check_field("diag_code", want.diag, m_tdata[17:15]);
          check_field("trusted_temp", want.trusted, $signed(m_tdata[30:18]));
          check_field("trusted_valid", want.trusted_ok, m_tdata[31]);
          check_field("proc_state", want.state, m_tdata[33:32]);
          check_field("init_done", want.init_done, m_tdata[34]);
          check_field("permissive", want.permissive, m_tdata[35]);
          check_field("heater_on", want.heater_on, m_tdata[36]);
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else if (stall_armed && !stall_done) begin
        stall_left = 200;
        stall_done = 1'b1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= snk_gap_pct);
      end
    end
  end

  // Stimulus helpers
  function automatic int fit12(input int v);
    return (v < -2048) ? -2048 : (v > 2047) ? 2047 : v;
  endfunction

  // clamp into the plausible range; with an inverted range only the field limits apply
  function automatic int keep_valid(input int v);
    int lo, hi;
    lo = lo_lim;
    hi = hi_lim;
    if (lo > hi) return fit12(v);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [31:0] tick_ms();
    clock_ms = clock_ms + $urandom_range(200, 1500);
    return clock_ms;
  endfunction

  function automatic bit link_ok();
    return $urandom_range(0, 9) != 0;
  endfunction

  // step direction that heads toward the middle of the plausible range
  function automatic int toward_mid(input int mag);
    return (2 * walk_t > int'(lo_lim) + int'(hi_lim)) ? -mag : mag;
  endfunction

  task automatic add_beat(input int a, input int b, input logic [31:0] ms,
                          input bit ok, input bit heat);
    sample_t s;
    s.ta = a[11:0];
    s.tb = b[11:0];
    s.ms = ms;
    s.comms = ok;
    s.heat = heat;
    sample_backlog.push_back(s);
    phase_beats++;
  endtask

  task automatic add_scenario();
    int kind, len, step, hold_v, nw, far;
    bit a_side;
    kind = $urandom_range(0, 99);
    nw = int'(agree_lim) / 2;
    if (nw > 30) nw = 30;
    a_side = $urandom_range(0, 1);
    if (kind < 35) begin
      // agreeing pair tracking a slowly wandering process
      len = $urandom_range(3, 12);
      repeat (len) begin
        walk_t = keep_valid(walk_t + jitter(20));
        add_beat(keep_valid(walk_t + jitter(nw)), keep_valid(walk_t + jitter(nw)),
                 tick_ms(), link_ok(), $urandom_range(0, 1));
      end
    end else if (kind < 50) begin
      // disagreement burst, short or long enough to confirm
      len = $urandom_range(1, 6);
      repeat (len) begin
        far = int'(agree_lim) + 1 + int'($urandom_range(0, 40));
        if (a_side) far = -far;
        add_beat(walk_t, keep_valid(walk_t + far), tick_ms(), link_ok(), $urandom_range(0, 1));
      end
    end else if (kind < 65) begin
      // one sensor frozen while the other follows a moving process
      len = $urandom_range(6, 12);
      step = toward_mid($urandom_range(2, 6));
      hold_v = walk_t;
      repeat (len) begin
        walk_t = keep_valid(walk_t + step);
        if (a_side) add_beat(hold_v, walk_t, tick_ms(), link_ok(), $urandom_range(0, 1));
        else        add_beat(walk_t, hold_v, tick_ms(), link_ok(), $urandom_range(0, 1));
      end
    end else if (kind < 75) begin
      // one sensor just outside the plausible range
      len = $urandom_range(1, 4);
      repeat (len) begin
        if ($urandom_range(0, 1)) far = int'(hi_lim) + 1 + int'($urandom_range(0, 100));
        else                      far = int'(lo_lim) - 1 - int'($urandom_range(0, 100));
        far = fit12(far);
        if (a_side) add_beat(far, walk_t, tick_ms(), link_ok(), $urandom_range(0, 1));
        else        add_beat(walk_t, far, tick_ms(), link_ok(), $urandom_range(0, 1));
      end
    end else if (kind < 87) begin
      // raw noise over every bit of every field
      len = $urandom_range(1, 3);
      repeat (len) add_beat($urandom, $urandom, $urandom, $urandom_range(0, 1),
                            $urandom_range(0, 1));
    end else begin
      // fast ramp toward the middle of the plausible range
      len = $urandom_range(5, 15);
      step = toward_mid($urandom_range(10, 60));
      repeat (len) begin
        walk_t = keep_valid(walk_t + step);
        add_beat(keep_valid(walk_t + jitter(nw)), keep_valid(walk_t + jitter(nw)),
                 tick_ms(), link_ok(), $urandom_range(0, 1));
      end
    end
  endtask

  task automatic set_reg(input rtsv_pkg::reg_index_t idx, input int val);
    logic [15:0] raw;
    raw = val[15:0];
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= raw;
    case (idx)
      rtsv_pkg::REG_VALID_LOW:     lo_lim      = raw[11:0];
      rtsv_pkg::REG_VALID_HIGH:    hi_lim      = raw[11:0];
      rtsv_pkg::REG_AGREE_LIMIT:   agree_lim   = raw[11:0];
      rtsv_pkg::REG_STUCK_LIMIT:   stuck_lim   = raw[11:0];
      rtsv_pkg::REG_MOVED_LIMIT:   moved_lim   = raw[11:0];
      rtsv_pkg::REG_WARNING_LEVEL: warn_lim    = raw[11:0];
      rtsv_pkg::REG_TRIP_LEVEL:    trip_lim    = raw[11:0];
      rtsv_pkg::REG_INIT_TIME_MS:  init_ms_lim = raw;
      default: ;
    endcase
  endtask

  task automatic load_regs(input int lo, input int hi, input int agr, input int stk,
                           input int moved, input int warn, input int trip, input int init_ms);
    set_reg(rtsv_pkg::REG_VALID_LOW, lo);
    set_reg(rtsv_pkg::REG_VALID_HIGH, hi);
    set_reg(rtsv_pkg::REG_AGREE_LIMIT, agr);
    set_reg(rtsv_pkg::REG_STUCK_LIMIT, stk);
    set_reg(rtsv_pkg::REG_MOVED_LIMIT, moved);
    set_reg(rtsv_pkg::REG_WARNING_LEVEL, warn);
    set_reg(rtsv_pkg::REG_TRIP_LEVEL, trip);
    set_reg(rtsv_pkg::REG_INIT_TIME_MS, init_ms);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic pick_regs();
    int lo, hi, warn;
    lo = int'($urandom_range(0, 1200)) - 600;
    hi = fit12(lo + int'($urandom_range(300, 1800)));
    warn = lo + int'($urandom_range(0, hi - lo));
    load_regs(lo, hi, $urandom_range(0, 40), $urandom_range(0, 4), $urandom_range(1, 30),
              warn, fit12(warn + int'($urandom_range(0, 300))), $urandom_range(0, 65535));
  endtask

  // wait until every beat is taken and every verdict has come back
  task automatic wait_drained();
    while (sample_backlog.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    phase_beats = 0;
    while (phase_beats < n) add_scenario();
    wait_drained();
  endtask

  // Test sequence
  initial begin
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // defaults, but initialization held off until the latest possible time
    load_regs(0, 1280, 16, 1, 8, 800, 960, 65535);
    add_beat(0, 0, 0, 1, 1);
    add_beat(-2048, 2047, 0, 0, 0);
    add_beat(2047, -2048, 32'hFFFF_FFFF, 1, 1);
    add_beat(1280, 1281, 1000, 1, 1);
    add_beat(500, 500, 65534, 1, 1);
    add_beat(100, 100, 65535, 1, 1);
    add_beat(100, 116, 66000, 1, 1);
    add_beat(100, 117, 67000, 1, 0);
    add_beat(100, 300, 68000, 1, 1);
    add_beat(100, 300, 69000, 1, 1);
    for (i = 0; i < 3; i++) add_beat(300, 300, 70000 + 1000 * i, 1, 1);
    add_beat(1280, 1280, 73000, 1, 1);
    add_beat(850, 850, 74000, 1, 1);
    // sensor a out of range restarts the window before the frozen-sensor runs
    add_beat(-1, 0, 76000, 1, 1);
    for (i = 0; i < 6; i++) add_beat(400, 400 + 3 * i, 77000 + 1000 * i, 1, 1);
    for (i = 1; i < 6; i++) add_beat(400 + 3 * i, 415, 83000 + 1000 * i, 1, 1);
    wait_drained();

    // defaults with one long output hold-off while input keeps coming
    phase_beats = 0;
    while (phase_beats < 250) add_scenario();
    stall_armed = 1'b1;
    wait_drained();

    // widest range, zero agreement band, every window change counts as stuck
    load_regs(-2048, 2047, 0, 4095, 0, -2048, 2047, 0);
    run_random(120);

    // full agreement band, stuck only on a full-scale change of the other sensor, levels inverted
    load_regs(-2048, 2047, 4095, 0, 4095, 2047, -2048, 0);
    run_random(120);

    // inverted plausible range: nothing is valid
    load_regs(50, -50, 16, 1, 8, 800, 960, 3000);
    run_random(40);

    pick_regs();
    run_random(200);

    // no idling on either side
    src_gap_pct = 0;
    snk_gap_pct = 0;
    pick_regs();
    run_random(200);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS redundant_temp_sensor_voter");
    end else begin
      $display("FAIL redundant_temp_sensor_voter");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL redundant_temp_sensor_voter");
    $finish;
  end

endmodule
